// ===== rtl/core/tpac_pkg.sv =====
// shared constants, codes and types of the traffic phase ack coordinator
package tpac_pkg;

    // lane geometry
    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);

    // field widths
    localparam int CMD_W      = 3;
    localparam int NODE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int COLOR_W    = 2;
    localparam int REMAIN_W   = 32;
    localparam int OUT_LANE_W = 3;
    localparam int TIME_W     = 9;
    localparam int SEC_W      = 8;
    localparam int MS_W       = 32;
    localparam int IVAL_W     = 16;
    localparam int PROD_W     = COUNT_W + 1 + SEC_W;
    localparam int ALU_W      = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_VEHICLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GREEN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GREEN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_MS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE        = 3'd6;

    // register reset values
    localparam logic [SEC_W-1:0]  RST_SEC_PER_VEHICLE = 8'd5;
    localparam logic [SEC_W-1:0]  RST_MIN_GREEN       = 8'd15;
    localparam logic [SEC_W-1:0]  RST_MAX_GREEN       = 8'd90;
    localparam logic [SEC_W-1:0]  RST_YELLOW_TIME     = 8'd5;
    localparam logic [SEC_W-1:0]  RST_FALLBACK_GREEN  = 8'd45;
    localparam logic [IVAL_W-1:0] RST_RESEND_MS       = 16'd100;
    localparam logic [NODE_W-1:0] RST_OWN_NODE        = 8'hAF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REQ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ACK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd5;

    // colour codes
    localparam logic [COLOR_W-1:0] C_RED     = 2'd0;
    localparam logic [COLOR_W-1:0] C_YELLOW  = 2'd1;
    localparam logic [COLOR_W-1:0] C_GREEN   = 2'd2;
    localparam logic [COLOR_W-1:0] C_UNKNOWN = 2'd3;

    // shared unit operations
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_MUL     = 2'd1;
    localparam logic [1:0] OP_ELAPSED = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
        logic [IVAL_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             ge;
    } t_alu_rsp;

    // colour a lane moves to on a phase change
    function automatic logic [COLOR_W-1:0] successor(input logic [COLOR_W-1:0] cur);
        logic [COLOR_W-1:0] nxt;
        case (cur)
            C_RED:    nxt = C_GREEN;
            C_GREEN:  nxt = C_RED;
            C_YELLOW: nxt = C_RED;
            default:  nxt = C_UNKNOWN;
        endcase
        return nxt;
    endfunction

endpackage

// ===== rtl/core/tpac_item_if.sv =====
// input item channel: valid, ready and the event fields
interface tpac_item_if
    import tpac_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [7:0]          lane;
    logic [NODE_W-1:0]   target_node;
    logic [COUNT_W-1:0]  vehicle_count;
    logic [COLOR_W-1:0]  color;
    logic [REMAIN_W-1:0] time_remain;

    modport source (
        output valid, cmd, lane, target_node, vehicle_count, color, time_remain,
        input  ready
    );
    modport sink (
        input  valid, cmd, lane, target_node, vehicle_count, color, time_remain,
        output ready
    );
endinterface

// ===== rtl/core/tpac_result_if.sv =====
// result channel: valid, ready and one command frame
interface tpac_result_if
    import tpac_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OUT_LANE_W-1:0] out_lane;
    logic [COLOR_W-1:0]    next_color;
    logic [TIME_W-1:0]     time_value;
    logic                  last;

    modport source (
        output valid, out_lane, next_color, time_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_lane, next_color, time_value, last,
        output ready
    );
endinterface

// ===== rtl/core/tpac_alu.sv =====
// shared arithmetic unit: add, green-time multiply, elapsed-time compare
module tpac_alu
    import tpac_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [PROD_W-1:0] w_prod;
    logic [ALU_W-1:0]  w_diff;

    // 17 x 8 product, the only multiply of the block
    assign w_prod = PROD_W'(i_req.a[COUNT_W:0]) * PROD_W'(i_req.b[SEC_W-1:0]);
    // modular elapsed time
    assign w_diff = i_req.a - i_req.b;

    always_comb begin
        o_rsp.ge = 1'b0;
        case (i_req.op)
            OP_ADD: begin
                o_rsp.value = i_req.a + i_req.b;
            end
            OP_MUL: begin
                o_rsp.value = ALU_W'(w_prod);
            end
            OP_ELAPSED: begin
                o_rsp.value = w_diff;
                o_rsp.ge    = (w_diff >= ALU_W'(i_req.c));
            end
            default: begin
                o_rsp.value = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/traffic_phase_ack_coordinator.sv =====
// traffic phase ack coordinator: sequencer, lane state and result register
// count, status, ack and tick items finish in idle; a request steps through sum,
// multiply, clamp and times, then an emit walk; check: a lane walk through the
// shared elapsed-time compare (after the times step for fallback times), then
// the emit walk; one frame per cycle unless the output stalls, one item at a time
// reset: synchronous active low, registers to defaults, lanes red, counts taken
module traffic_phase_ack_coordinator
    import tpac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tpac_item_if.sink             i_in,
    tpac_result_if.source         o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_TIMES = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

    // configuration registers
    logic [SEC_W-1:0]  r_sec_per_vehicle;
    logic [SEC_W-1:0]  r_min_green;
    logic [SEC_W-1:0]  r_max_green;
    logic [SEC_W-1:0]  r_yellow_time;
    logic [SEC_W-1:0]  r_fallback_green;
    logic [IVAL_W-1:0] r_resend_ms;
    logic [NODE_W-1:0] r_own_node;

    // lane state
    logic [COUNT_W-1:0] r_counts   [LANES];
    logic [COLOR_W-1:0] r_cur      [LANES];
    logic [COLOR_W-1:0] r_next     [LANES];
    logic [TIME_W-1:0]  r_time     [LANES];
    logic [MS_W-1:0]    r_sent_at  [LANES];
    logic [LANES-1:0]   r_waiting;
    logic [LANES-1:0]   r_acked;
    logic [LANES-1:0]   r_ever;

    // global state
    logic [REMAIN_W-1:0] r_first_remain;
    logic [2:0]          r_acks;
    logic                r_resend_active;
    logic                r_accepting;
    logic [MS_W-1:0]     r_now;

    // sequencer
    logic [2:0]        r_state;
    logic [LANE_W-1:0] r_k;
    logic [LANES-1:0]  r_mask;
    logic              r_req;
    logic [PROD_W-1:0] r_acc;
    logic [SEC_W-1:0]  r_green;

    // result register
    logic                  r_out_valid;
    logic [OUT_LANE_W-1:0] r_out_lane;
    logic [COLOR_W-1:0]    r_out_color;
    logic [TIME_W-1:0]     r_out_time;
    logic                  r_out_last;

    t_alu_req w_alu_req;
    t_alu_rsp w_alu_rsp;

    logic              w_in_acc;
    logic              w_frame_ok;
    logic [7:0]        w_lane_m1;
    logic [LANE_W-1:0] w_li;
    logic [2:0]        w_acks_inc;
    logic              w_fallback;
    logic              w_out_free;
    logic              w_load;
    logic [LANES-1:0]  w_mask_hi;
    logic [TIME_W-1:0] w_green_yellow;
    logic [SEC_W-1:0]  w_clamped;

    tpac_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // handshake and decode
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_lane_m1   = i_in.lane - 8'd1;
    assign w_li        = w_lane_m1[LANE_W-1:0];
    assign w_frame_ok  = (i_in.lane >= 8'd1) && (i_in.lane <= 8'(LANES))
                         && (i_in.target_node == r_own_node);
    assign w_acks_inc  = r_acked[w_li] ? r_acks : r_acks + 3'd1;
    assign w_fallback  = (r_first_remain <= REMAIN_W'(2)) && (r_acks < 3'(LANES));
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_load      = (r_state == S_EMIT) && r_mask[r_k] && w_out_free;
    assign w_mask_hi   = r_mask >> r_k;
    assign w_green_yellow = w_alu_rsp.value[TIME_W-1:0];

    // clamp order: below min wins over above max
    always_comb begin
        if (r_acc < PROD_W'(r_min_green)) begin
            w_clamped = r_min_green;
        end else if (r_acc > PROD_W'(r_max_green)) begin
            w_clamped = r_max_green;
        end else begin
            w_clamped = r_acc[SEC_W-1:0];
        end
    end

    // shared unit operand select
    always_comb begin
        w_alu_req = '0;
        case (r_state)
            S_SUM: begin
                w_alu_req.op = OP_ADD;
                if (r_cur[0] == C_RED) begin
                    w_alu_req.a = ALU_W'(r_counts[0]);
                    w_alu_req.b = ALU_W'(r_counts[2]);
                end else begin
                    w_alu_req.a = ALU_W'(r_counts[1]);
                    w_alu_req.b = ALU_W'(r_counts[3]);
                end
            end
            S_MUL: begin
                w_alu_req.op = OP_MUL;
                w_alu_req.a  = ALU_W'(r_acc);
                w_alu_req.b  = ALU_W'(r_sec_per_vehicle);
            end
            S_TIMES: begin
                w_alu_req.op = OP_ADD;
                w_alu_req.a  = ALU_W'(r_green);
                w_alu_req.b  = ALU_W'(r_yellow_time);
            end
            S_EVAL: begin
                w_alu_req.op = OP_ELAPSED;
                w_alu_req.a  = r_now;
                w_alu_req.b  = r_sent_at[r_k];
                w_alu_req.c  = r_resend_ms;
            end
            default: begin
                w_alu_req.op = OP_ADD;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_per_vehicle <= RST_SEC_PER_VEHICLE;
            r_min_green       <= RST_MIN_GREEN;
            r_max_green       <= RST_MAX_GREEN;
            r_yellow_time     <= RST_YELLOW_TIME;
            r_fallback_green  <= RST_FALLBACK_GREEN;
            r_resend_ms       <= RST_RESEND_MS;
            r_own_node        <= RST_OWN_NODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEC_PER_VEHICLE: r_sec_per_vehicle <= i_cfg_data[SEC_W-1:0];
                CFG_MIN_GREEN:       r_min_green       <= i_cfg_data[SEC_W-1:0];
                CFG_MAX_GREEN:       r_max_green       <= i_cfg_data[SEC_W-1:0];
                CFG_YELLOW_TIME:     r_yellow_time     <= i_cfg_data[SEC_W-1:0];
                CFG_FALLBACK_GREEN:  r_fallback_green  <= i_cfg_data[SEC_W-1:0];
                CFG_RESEND_MS:       r_resend_ms       <= i_cfg_data[IVAL_W-1:0];
                CFG_OWN_NODE:        r_own_node        <= i_cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_counts[i]  <= '0;
                r_cur[i]     <= C_RED;
                r_next[i]    <= C_UNKNOWN;
                r_time[i]    <= '0;
                r_sent_at[i] <= '0;
            end
            r_waiting       <= '0;
            r_acked         <= '0;
            r_ever          <= '0;
            r_first_remain  <= '0;
            r_acks          <= '0;
            r_resend_active <= 1'b0;
            r_accepting     <= 1'b1;
            r_now           <= '0;
            r_state         <= S_IDLE;
            r_k             <= '0;
            r_mask          <= '0;
            r_req           <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // result register drains when taken and nothing new is loaded
            if (o_out.ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (w_in_acc) begin
                        case (i_in.cmd)
                            CMD_COUNT: begin
                                if (i_in.lane < 8'(LANES) && r_accepting) begin
                                    r_counts[i_in.lane[LANE_W-1:0]] <= i_in.vehicle_count;
                                end
                            end
                            CMD_STATUS: begin
                                if (w_frame_ok) begin
                                    r_cur[w_li] <= i_in.color;
                                    if (w_li == '0) begin
                                        r_first_remain <= i_in.time_remain;
                                    end
                                end
                            end
                            CMD_REQ: begin
                                if (w_frame_ok) begin
                                    r_accepting <= 1'b0;
                                    r_req       <= 1'b1;
                                    r_state     <= S_SUM;
                                end
                            end
                            CMD_ACK: begin
                                if (w_frame_ok && r_waiting[w_li]) begin
                                    r_waiting[w_li] <= 1'b0;
                                    r_acked[w_li]   <= 1'b1;
                                    r_acks          <= w_acks_inc;
                                    if (w_acks_inc == 3'(LANES)) begin
                                        r_resend_active <= 1'b0;
                                    end
                                end
                            end
                            CMD_TICK: begin
                                r_now <= r_now + MS_W'(1);
                            end
                            CMD_CHECK: begin
                                if (r_resend_active) begin
                                    r_req <= 1'b0;
                                    if (w_fallback) begin
                                        r_waiting <= '1;
                                        r_green   <= r_fallback_green;
                                        r_state   <= S_TIMES;
                                    end else begin
                                        r_state   <= S_EVAL;
                                    end
                                    if (r_first_remain <= REMAIN_W'(1)) begin
                                        r_accepting     <= 1'b1;
                                        r_resend_active <= 1'b0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    r_acc   <= w_alu_rsp.value[PROD_W-1:0];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc   <= w_alu_rsp.value[PROD_W-1:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_green <= w_clamped;
                    r_state <= S_TIMES;
                end
                S_TIMES: begin
                    // per-lane times from the new colours, all lanes at once
                    for (int i = 0; i < LANES; i++) begin
                        logic [COLOR_W-1:0] nc;
                        nc = r_req ? successor(r_cur[i]) : r_next[i];
                        r_next[i] <= nc;
                        if (nc == C_RED) begin
                            r_time[i] <= w_green_yellow;
                        end else if (nc == C_GREEN) begin
                            r_time[i] <= TIME_W'(r_green);
                        end
                    end
                    r_k <= '0;
                    if (r_req) begin
                        r_waiting       <= '1;
                        r_acked         <= '0;
                        r_acks          <= '0;
                        r_resend_active <= 1'b1;
                        r_mask          <= '1;
                        r_state         <= S_EMIT;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // one lane per cycle through the elapsed-time compare
                    r_mask[r_k] <= r_waiting[r_k] && (!r_ever[r_k] || w_alu_rsp.ge);
                    if (r_k == LAST_LANE) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k <= r_k + LANE_W'(1);
                    end
                end
                S_EMIT: begin
                    if (!r_mask[r_k] || w_out_free) begin
                        if (r_mask[r_k]) begin
                            r_out_valid    <= 1'b1;
                            r_out_lane     <= OUT_LANE_W'(r_k) + OUT_LANE_W'(1);
                            r_out_color    <= r_next[r_k];
                            r_out_time     <= r_time[r_k];
                            r_out_last     <= (w_mask_hi == LANES'(1));
                            r_sent_at[r_k] <= r_now;
                            r_ever[r_k]    <= 1'b1;
                        end
                        if (r_k == LAST_LANE) begin
                            r_k     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + LANE_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result beat
    assign o_out.valid      = r_out_valid;
    assign o_out.out_lane   = r_out_lane;
    assign o_out.next_color = r_out_color;
    assign o_out.time_value = r_out_time;
    assign o_out.last       = r_out_last;

`ifndef SYNTHESIS
    a_acks_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acks <= 3'(LANES))
        else $error("ack count above lane count");

    a_beat_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result beat loaded outside emit walk");

    a_resend_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_resend_active) |-> $past(w_in_acc
            && (i_in.cmd == CMD_ACK || i_in.cmd == CMD_CHECK)))
        else $error("resend stopped without ack or check");

    a_accept_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_accepting) |-> $past(w_in_acc && i_in.cmd == CMD_CHECK))
        else $error("counts resumed without check");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_k != LAST_LANE) |=> !i_in.ready)
        else $error("input taken during emit walk");
`endif

endmodule
